/* hdl/sial_pkg.sv */
// Shared types and constants for the seat interlock alarm sequencer.
`timescale 1ns / 1ps

package sial_pkg;

  localparam int unsigned NUM_CFG_REGS = 5;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned SECS_W       = 8;
  localparam int unsigned PHASE_W      = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_WAIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PTO_WAIT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PTO_BRAKE_BUZZ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_ON       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PTO_RUN_BUZZ   = 3'd4;

  // Reset values of the configuration registers
  localparam logic [SECS_W-1:0] GEAR_WAIT_RST      = 8'd2;
  localparam logic [SECS_W-1:0] PTO_WAIT_RST       = 8'd3;
  localparam logic [SECS_W-1:0] PTO_BRAKE_BUZZ_RST = 8'd5;
  localparam logic [SECS_W-1:0] RELAY_ON_RST       = 8'd5;
  localparam logic [SECS_W-1:0] PTO_RUN_BUZZ_RST   = 8'd7;

  localparam logic [SECS_W-1:0] SECS_MAX = '1;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE       = 4'd0,
    PH_GEAR_WAIT  = 4'd1,
    PH_GEAR_BUZZ  = 4'd2,
    PH_BRAKE_BUZZ = 4'd3,
    PH_PB_WAIT    = 4'd4,
    PH_PB_BUZZ    = 4'd5,
    PH_RELAY      = 4'd6,
    PH_PR_WAIT    = 4'd7,
    PH_PR_BUZZ    = 4'd8
  } phase_t;

  typedef struct packed {
    logic [SECS_W-1:0] gear_wait;
    logic [SECS_W-1:0] pto_wait;
    logic [SECS_W-1:0] pto_brake_buzz;
    logic [SECS_W-1:0] relay_on;
    logic [SECS_W-1:0] pto_run_buzz;
  } cfg_t;

  typedef struct packed {
    logic seat;
    logic pto;
    logic brake;
    logic gear;
    logic tick;
  } sample_t;

endpackage

/* hdl/sial_cfg.sv */
// Configuration register bank with timing limits.
`timescale 1ns / 1ps

module sial_cfg
  import sial_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [SECS_W-1:0]    wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gear_wait      <= GEAR_WAIT_RST;
      cfg.pto_wait       <= PTO_WAIT_RST;
      cfg.pto_brake_buzz <= PTO_BRAKE_BUZZ_RST;
      cfg.relay_on       <= RELAY_ON_RST;
      cfg.pto_run_buzz   <= PTO_RUN_BUZZ_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_GEAR_WAIT:      cfg.gear_wait      <= wr_data;
        CFG_PTO_WAIT:       cfg.pto_wait       <= wr_data;
        CFG_PTO_BRAKE_BUZZ: cfg.pto_brake_buzz <= wr_data;
        CFG_RELAY_ON:       cfg.relay_on       <= wr_data;
        CFG_PTO_RUN_BUZZ:   cfg.pto_run_buzz   <= wr_data;
        default: ;  // out-of-range index is dropped
      endcase
    end
  end

endmodule

/* hdl/sial_step.sv */
// Phase sequencer: state update and registered alarm outputs.
`timescale 1ns / 1ps

module sial_step
  import sial_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  sample_t smp,
  input  cfg_t    cfg,
  output phase_t  phase_reg,
  output logic    buzzer,
  output logic    relay
);

  logic [SECS_W-1:0] seconds_count;
  logic [SECS_W-1:0] seconds_next;
  logic [SECS_W-1:0] secs_inc;
  logic [SECS_W-1:0] limit;
  logic              timed;
  logic              c1, c2, cp, cr;
  phase_t            phase_next;

  assign c1 = !smp.seat && !smp.pto &&  smp.brake &&  smp.gear;
  assign c2 = !smp.seat && !smp.pto &&  smp.brake && !smp.gear;
  assign cp = !smp.seat &&  smp.pto &&  smp.brake;
  assign cr = !smp.seat &&  smp.pto && !smp.brake;

  assign secs_inc = (smp.tick && seconds_count != SECS_MAX) ? seconds_count + 1'b1
                                                            : seconds_count;

  always_comb begin
    timed = 1'b1;
    limit = cfg.gear_wait;
    unique case (phase_reg)
      PH_GEAR_WAIT: limit = cfg.gear_wait;
      PH_PB_WAIT:   limit = cfg.pto_wait;
      PH_PB_BUZZ:   limit = cfg.pto_brake_buzz;
      PH_RELAY:     limit = cfg.relay_on;
      PH_PR_WAIT:   limit = cfg.pto_wait;
      PH_PR_BUZZ:   limit = cfg.pto_run_buzz;
      default:      timed = 1'b0;
    endcase
  end

  always_comb begin
    phase_next   = phase_reg;
    seconds_next = seconds_count;
    if (timed) begin
      seconds_next = secs_inc;
      if (c2 || secs_inc >= limit) begin
        seconds_next = '0;
        unique case (phase_reg)
          PH_GEAR_WAIT: phase_next = c1 ? PH_GEAR_BUZZ : PH_IDLE;
          PH_PB_WAIT:   phase_next = PH_PB_BUZZ;
          PH_PB_BUZZ:   phase_next = PH_RELAY;
          PH_PR_WAIT:   phase_next = PH_PR_BUZZ;
          default:      phase_next = PH_IDLE;
        endcase
      end
    end else if (phase_reg == PH_GEAR_BUZZ) begin
      if (!c1) phase_next = PH_IDLE;
    end else if (phase_reg == PH_BRAKE_BUZZ) begin
      if (!c2) phase_next = PH_IDLE;
    end else begin
      // idle, or any stray code: pick a sequence from the seat-empty condition
      phase_next = PH_IDLE;
      if (c1 || c2 || cp || cr) begin
        seconds_next = '0;
        priority if (c1) phase_next = PH_GEAR_WAIT;
        else if (c2)     phase_next = PH_BRAKE_BUZZ;
        else if (cp)     phase_next = PH_PB_WAIT;
        else             phase_next = PH_PR_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_IDLE;
      seconds_count <= '0;
      buzzer        <= 1'b0;
      relay         <= 1'b0;
    end else if (adv) begin
      phase_reg     <= phase_next;
      seconds_count <= seconds_next;
      buzzer        <= (phase_next == PH_GEAR_BUZZ) || (phase_next == PH_BRAKE_BUZZ) ||
                       (phase_next == PH_PB_BUZZ)   || (phase_next == PH_PR_BUZZ);
      relay         <= (phase_next == PH_RELAY);
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(phase_reg) && $stable(seconds_count))
    else $error("sequencer state moved without a transaction");

  a_relay_excl_buzz: assert property (@(posedge clk) disable iff (rst)
    !(relay && buzzer))
    else $error("relay and buzzer driven together");

  a_start_clears_secs: assert property (@(posedge clk) disable iff (rst)
    (adv && phase_reg == PH_IDLE && phase_next != PH_IDLE) |=> seconds_count == '0)
    else $error("sequence start did not clear seconds count");

  a_relay_after_buzz: assert property (@(posedge clk) disable iff (rst)
    (phase_reg == PH_RELAY && $past(phase_reg) != PH_RELAY)
      |-> $past(phase_reg) == PH_PB_BUZZ)
    else $error("relay phase entered from wrong phase");
`endif

endmodule

/* hdl/seat_interlock_alarm_sequencer_core.sv */
// Top level of the seat interlock alarm sequencer.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one sample of the seat, PTO,
//   hand brake and gear switches plus a one-second tick flag per transaction.
//   Output channel (out_valid/out_ready) returns one result per input:
//   buzzer_on, relay_on and the phase reached after that sample.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the five timing limits in seconds; cfg_ready is always high, and an
//   index above 4 is ignored. Write only while no sample is in flight.
//   Data path: a sample is registered in the sample stage, then evaluated
//   against the sequencer state into the registered result outputs.
//   Throughput: one sample per cycle while out_ready is high, set by the phase update.
//   When out_ready is low the result holds, the sample register fills, and
//   in_ready drops until the result is taken.
//   Reset (rst, synchronous) returns the sequencer to idle, clears the
//   seconds count, empties both stages and restores the default limits.
module seat_interlock_alarm_sequencer_core
  import sial_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SECS_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 seat_sense,
  input  logic                 pto_engaged,
  input  logic                 park_brake,
  input  logic                 gear_engaged,
  input  logic                 second_tick,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 buzzer_on,
  output logic                 relay_on,
  output logic [PHASE_W-1:0]   phase
);

  cfg_t    cfg;
  sample_t smp;
  logic    smp_valid;
  logic    adv;
  phase_t  phase_q;

  assign cfg_ready = 1'b1;

  // sample stage moves into the result stage when that stage is free or drains
  assign adv      = smp_valid && (!out_valid || out_ready);
  assign in_ready = !smp_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) smp_valid <= in_valid;
      if (adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp <= '{seat: seat_sense, pto: pto_engaged, brake: park_brake,
               gear: gear_engaged, tick: second_tick};
    end
  end

  sial_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sial_step u_step (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .smp       (smp),
    .cfg       (cfg),
    .phase_reg (phase_q),
    .buzzer    (buzzer_on),
    .relay     (relay_on)
  );

  assign phase = phase_q;

endmodule

/* sim/alarm_sequence_checker.sv */
// Checker for the seat interlock alarm sequencer: predicts each result and compares it.
`timescale 1ns / 1ps

module alarm_sequence_checker
  import sial_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SECS_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 seat_sense,
  input  logic                 pto_engaged,
  input  logic                 park_brake,
  input  logic                 gear_engaged,
  input  logic                 second_tick,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 buzzer_on,
  input  logic                 relay_on,
  input  logic [PHASE_W-1:0]   phase,
  output int                   mismatches = 0,
  output int                   outstanding = 0
);

  typedef struct packed {
    logic               buzz;
    logic               relay;
    logic [PHASE_W-1:0] ph;
  } alarm_t;

  alarm_t            alarm_q[$];
  cfg_t              limits;
  phase_t            seq_phase;
  logic [SECS_W-1:0] secs;
  int                errs = 0;

  function automatic logic [SECS_W-1:0] limit_of(phase_t p);
    case (p)
      PH_GEAR_WAIT:           return limits.gear_wait;
      PH_PB_WAIT, PH_PR_WAIT: return limits.pto_wait;
      PH_PB_BUZZ:             return limits.pto_brake_buzz;
      PH_RELAY:               return limits.relay_on;
      default:                return limits.pto_run_buzz;
    endcase
  endfunction

  // Advance the sequencer by one sample and return the outputs it shows after it.
  function automatic alarm_t step_sequencer(sample_t s);
    logic   empty;
    logic   gear_hold;
    logic   brake_hold;
    logic   pto_brake;
    logic   pto_run;
    alarm_t a;
    empty      = !s.seat;
    gear_hold  = empty && !s.pto && s.brake && s.gear;
    brake_hold = empty && !s.pto && s.brake && !s.gear;
    pto_brake  = empty && s.pto && s.brake;
    pto_run    = empty && s.pto && !s.brake;
    case (seq_phase)
      PH_GEAR_WAIT, PH_PB_WAIT, PH_PB_BUZZ, PH_RELAY, PH_PR_WAIT, PH_PR_BUZZ: begin
        if (s.tick && secs != SECS_MAX)
          secs = secs + 1'b1;
        // seat empty, PTO off, brake on with gear out cuts any timed phase short
        if (brake_hold || secs >= limit_of(seq_phase)) begin
          secs = '0;
          case (seq_phase)
            PH_GEAR_WAIT: seq_phase = gear_hold ? PH_GEAR_BUZZ : PH_IDLE;
            PH_PB_WAIT:   seq_phase = PH_PB_BUZZ;
            PH_PB_BUZZ:   seq_phase = PH_RELAY;
            PH_PR_WAIT:   seq_phase = PH_PR_BUZZ;
            default:      seq_phase = PH_IDLE;
          endcase
        end
      end
      PH_GEAR_BUZZ: begin
        if (!gear_hold)
          seq_phase = PH_IDLE;
      end
      PH_BRAKE_BUZZ: begin
        if (!brake_hold)
          seq_phase = PH_IDLE;
      end
      default: begin
        seq_phase = PH_IDLE;
        if (gear_hold || brake_hold || pto_brake || pto_run) begin
          secs = '0;
          if (gear_hold)
            seq_phase = PH_GEAR_WAIT;
          else if (brake_hold)
            seq_phase = PH_BRAKE_BUZZ;
          else if (pto_brake)
            seq_phase = PH_PB_WAIT;
          else
            seq_phase = PH_PR_WAIT;
        end
      end
    endcase
    a.buzz  = seq_phase inside {PH_GEAR_BUZZ, PH_BRAKE_BUZZ, PH_PB_BUZZ, PH_PR_BUZZ};
    a.relay = (seq_phase == PH_RELAY);
    a.ph    = seq_phase;
    return a;
  endfunction

  always @(posedge clk) begin
    alarm_t want;
    if (rst) begin
      limits    = {GEAR_WAIT_RST, PTO_WAIT_RST, PTO_BRAKE_BUZZ_RST, RELAY_ON_RST,
                   PTO_RUN_BUZZ_RST};
      seq_phase = PH_IDLE;
      secs      = '0;
      alarm_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (alarm_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result buzz=%0b relay=%0b phase=%0d", $realtime,
                     buzzer_on, relay_on, phase);
        end else begin
          want = alarm_q.pop_front();
          if (buzzer_on !== want.buzz || relay_on !== want.relay || phase !== want.ph) begin
            errs++;
            if (errs <= 10)
              $display({"%0t: expected buzz=%0b relay=%0b phase=%0d, ",
                        "got buzz=%0b relay=%0b phase=%0d"},
                       $realtime, want.buzz, want.relay, want.ph, buzzer_on, relay_on, phase);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GEAR_WAIT:      limits.gear_wait      = cfg_data;
          CFG_PTO_WAIT:       limits.pto_wait       = cfg_data;
          CFG_PTO_BRAKE_BUZZ: limits.pto_brake_buzz = cfg_data;
          CFG_RELAY_ON:       limits.relay_on       = cfg_data;
          CFG_PTO_RUN_BUZZ:   limits.pto_run_buzz   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        alarm_q.push_back(step_sequencer({seat_sense, pto_engaged, park_brake, gear_engaged,
                                          second_tick}));
    end
    mismatches  <= errs;
    outstanding <= alarm_q.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top for the seat interlock alarm sequencer: stimulus, reset and verdict.
`timescale 1ns / 1ps

module tb;
  import sial_pkg::*;

  typedef enum int {
    COND_GEAR, COND_BRAKE, COND_PTO_BRAKE, COND_PTO_RUN, COND_NONE, COND_SEAT, COND_NOISE
  } cond_e;

  // short walk through every phase and transition, with all limits at one second
  localparam cond_e DIR_COND [24] = '{
    COND_SEAT, COND_NONE, COND_GEAR, COND_GEAR, COND_GEAR, COND_GEAR, COND_SEAT, COND_GEAR,
    COND_NONE, COND_BRAKE, COND_BRAKE, COND_GEAR, COND_PTO_BRAKE, COND_BRAKE, COND_PTO_BRAKE,
    COND_SEAT, COND_PTO_RUN, COND_PTO_RUN, COND_NONE, COND_BRAKE, COND_PTO_BRAKE,
    COND_PTO_BRAKE, COND_PTO_RUN, COND_BRAKE};
  localparam bit DIR_TICK [24] = '{
    1, 0, 0, 0, 1, 0, 0, 1, 1, 0, 1, 0, 0, 0, 1, 1, 1, 1, 0, 0, 0, 1, 1, 0};

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SECS_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 seat_sense = 1'b1;
  logic                 pto_engaged = 1'b0;
  logic                 park_brake = 1'b0;
  logic                 gear_engaged = 1'b0;
  logic                 second_tick = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 buzzer_on;
  logic                 relay_on;
  logic [PHASE_W-1:0]   phase;
  int                   mismatches;
  int                   outstanding;
  int                   calm_left = 0;

  seat_interlock_alarm_sequencer_core dut (.*);

  alarm_sequence_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("[seat_interlock_alarm_sequencer_core] ERROR");
    $finish;
  end

  // Result side: bursts of random readiness, plus long hold-offs that back up the input
  initial begin
    int hold_left;
    int burst_left;
    int ready_pct;
    int cycle_no;
    bit held_once;
    hold_left  = 0;
    burst_left = 0;
    ready_pct  = 100;
    cycle_no   = 0;
    held_once  = 1'b0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (hold_left == 0 && burst_left == 0) begin
        if ((!held_once && cycle_no > 400) || $urandom_range(199) == 0) begin
          hold_left = $urandom_range(60, 30);
          held_once = 1'b1;
        end else begin
          burst_left = $urandom_range(30, 1);
          ready_pct  = $urandom_range(1) ? 100 : $urandom_range(90, 30);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        burst_left--;
        out_ready <= ($urandom_range(99) < ready_pct);
      end
    end
  end

  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      calm_left = $urandom_range(40, 10);
      return 0;
    end
    if (r < 65)
      return 0;
    if (r < 92)
      return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Switch levels for a condition; the switches it leaves free are random.
  function automatic sample_t cond_sample(cond_e c, bit tick);
    sample_t s;
    s = sample_t'(5'($urandom_range(31)));
    case (c)
      COND_GEAR:      {s.seat, s.pto, s.brake, s.gear} = 4'b0011;
      COND_BRAKE:     {s.seat, s.pto, s.brake, s.gear} = 4'b0010;
      COND_PTO_BRAKE: {s.seat, s.pto, s.brake} = 3'b011;
      COND_PTO_RUN:   {s.seat, s.pto, s.brake} = 3'b010;
      COND_NONE:      {s.seat, s.pto, s.brake} = 3'b000;
      COND_SEAT:      s.seat = 1'b1;
      default: ;
    endcase
    s.tick = tick;
    return s;
  endfunction

  function automatic cond_e pick_cond();
    int r;
    r = $urandom_range(99);
    if (r < 22) return COND_GEAR;
    if (r < 34) return COND_BRAKE;
    if (r < 60) return COND_PTO_BRAKE;
    if (r < 84) return COND_PTO_RUN;
    if (r < 90) return COND_NONE;
    if (r < 96) return COND_SEAT;
    return COND_NOISE;
  endfunction

  task automatic send_sample(sample_t s);
    int gap;
    gap = next_gap();
    in_valid     <= 1'b1;
    seat_sense   <= s.seat;
    pto_engaged  <= s.pto;
    park_brake   <= s.brake;
    gear_engaged <= s.gear;
    second_tick  <= s.tick;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SECS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic set_limits(cfg_t lim);
    cfg_write(CFG_GEAR_WAIT, lim.gear_wait);
    cfg_write(CFG_PTO_WAIT, lim.pto_wait);
    cfg_write(CFG_PTO_BRAKE_BUZZ, lim.pto_brake_buzz);
    cfg_write(CFG_RELAY_ON, lim.relay_on);
    cfg_write(CFG_PTO_RUN_BUZZ, lim.pto_run_buzz);
    // unmapped index, must leave the limits alone
    cfg_write(CFG_IDX_W'(NUM_CFG_REGS + $urandom_range(2)), SECS_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Runs of one switch condition with random ticks, broken up by stray samples
  task automatic run_random(int n_items);
    cond_e c;
    int    run_len;
    int    k;
    k = 0;
    while (k < n_items) begin
      c       = pick_cond();
      run_len = $urandom_range(60, 1);
      repeat (run_len) begin
        if ($urandom_range(99) < 8)
          send_sample(cond_sample(COND_NOISE, $urandom_range(1)));
        else
          send_sample(cond_sample(c, $urandom_range(99) < 70));
        k++;
      end
    end
  endtask

  initial begin
    cfg_t lim;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    run_random(300);
    drain();

    set_limits({5{8'd1}});
    for (int i = 0; i < 24; i++)
      send_sample(cond_sample(DIR_COND[i], DIR_TICK[i]));
    run_random(380);
    drain();

    // zero limits end every timed phase on its first sample
    set_limits('0);
    run_random(200);
    drain();

    set_limits('1);
    repeat (258) send_sample(cond_sample(COND_GEAR, 1'b1));
    send_sample(cond_sample(COND_SEAT, 1'b0));
    repeat (262) send_sample(cond_sample(COND_PTO_BRAKE, 1'b1));
    send_sample(cond_sample(COND_BRAKE, 1'b0));
    drain();

    lim.gear_wait      = $urandom_range(12, 1);
    lim.pto_wait       = $urandom_range(12, 1);
    lim.pto_brake_buzz = $urandom_range(12, 1);
    lim.relay_on       = $urandom_range(12, 1);
    lim.pto_run_buzz   = $urandom_range(12, 1);
    set_limits(lim);
    run_random(450);
    drain();

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("[seat_interlock_alarm_sequencer_core] OK");
    else
      $display("[seat_interlock_alarm_sequencer_core] ERROR");
    $finish;
  end

endmodule
